// File: rtl/clock_replacement_tag_cache_assert.svh
// assertion macros for the clock replacement tag cache
// used by the top level only; no other dependencies
`ifndef CLOCK_REPLACEMENT_TAG_CACHE_ASSERT_SVH
`define CLOCK_REPLACEMENT_TAG_CACHE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CTC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ctc assertion failed");

// next-cycle implication, disabled during reset
`define CTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ctc assertion failed");

`endif

// File: rtl/ctc_pkg.sv
// shared types and constants for the clock replacement tag cache
// no dependencies
package ctc_pkg;

  localparam int SLOTS      = 16;
  localparam int TAG_BITS   = 32;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int OCC_W      = $clog2(SLOTS + 1);
  localparam int CMD_W      = 2;
  localparam int KEY_W      = 32;
  localparam int SLOT_OUT_W = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET   = 2'd0,
    CMD_GET   = 2'd1,
    CMD_FLUSH = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_REJECT,
    RES_HIT,
    RES_FILL
  } res_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SWEEP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic      capture;
    logic      clear_all;
    logic      touch;
    logic      place;
    logic      sweep_step;
    logic      write_result;
    res_kind_t res_kind;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             store_failed;
    logic             hit;
    logic             full;
    logic             ref_at_hand;
    logic             res_free;
  } dp_status_t;

endpackage

// File: rtl/ctc_if.sv
// request and response channel interfaces for the clock replacement tag cache
// depends on ctc_pkg
interface ctc_req_if;
  logic                          valid;
  logic                          ready;
  logic [ctc_pkg::CMD_W-1:0]     command;
  logic [ctc_pkg::KEY_W-1:0]     key_tag;
  logic                          store_failed;

  modport source(output valid, command, key_tag, store_failed, input ready);
  modport sink(input valid, command, key_tag, store_failed, output ready);
endinterface

interface ctc_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            status;
  logic                            hit;
  logic [ctc_pkg::SLOT_OUT_W-1:0]  slot;
  logic                            evicted;
  logic [ctc_pkg::KEY_W-1:0]       evicted_tag;

  modport source(output valid, status, hit, slot, evicted, evicted_tag, input ready);
  modport sink(input valid, status, hit, slot, evicted, evicted_tag, output ready);
endinterface

// File: rtl/ctc_dp.sv
// datapath: tag directory, valid and reference bits, clock hand, result register
// depends on ctc_pkg
module ctc_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [ctc_pkg::CMD_W-1:0]       req_command,
  input  logic [ctc_pkg::KEY_W-1:0]       req_key_tag,
  input  logic                            req_store_failed,
  input  ctc_pkg::ctrl_cmd_t              cmd,
  output ctc_pkg::dp_status_t             dir_status,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output logic                            rsp_status,
  output logic                            rsp_hit,
  output logic [ctc_pkg::SLOT_OUT_W-1:0]  rsp_slot,
  output logic                            rsp_evicted,
  output logic [ctc_pkg::KEY_W-1:0]       rsp_evicted_tag
);

  logic [ctc_pkg::CMD_W-1:0]    cmd_q;
  logic [ctc_pkg::TAG_BITS-1:0] tag_q;
  logic                         fail_q;

  logic [ctc_pkg::TAG_BITS-1:0] tag_store [ctc_pkg::SLOTS];
  logic [ctc_pkg::SLOTS-1:0]    valid_bits;
  logic [ctc_pkg::SLOTS-1:0]    recent_bits;
  logic [ctc_pkg::SLOT_W-1:0]   hand;
  logic [ctc_pkg::OCC_W-1:0]    occupancy;

  logic                         hit;
  logic [ctc_pkg::SLOT_W-1:0]   where;
  logic [ctc_pkg::SLOT_W-1:0]   hand_next;
  logic                         full;
  logic                         res_free;

  // tags are unique among valid slots, so an or of matching indices encodes the hit
  always_comb begin
    hit   = 1'b0;
    where = '0;
    for (int i = 0; i < ctc_pkg::SLOTS; i++) begin
      if (valid_bits[i] && (tag_store[i] == tag_q)) begin
        hit   = 1'b1;
        where = where | ctc_pkg::SLOT_W'(i);
      end
    end
  end

  assign hand_next = (hand == ctc_pkg::SLOT_W'(ctc_pkg::SLOTS - 1)) ?
                     '0 : hand + ctc_pkg::SLOT_W'(1);
  assign full      = (occupancy == ctc_pkg::OCC_W'(ctc_pkg::SLOTS));
  assign res_free  = !rsp_valid || rsp_ready;

  assign dir_status.command      = cmd_q;
  assign dir_status.store_failed = fail_q;
  assign dir_status.hit          = hit;
  assign dir_status.full         = full;
  assign dir_status.ref_at_hand  = recent_bits[hand];
  assign dir_status.res_free     = res_free;

  // request capture and tag store, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q  <= req_command;
      tag_q  <= ctc_pkg::TAG_BITS'(req_key_tag);
      fail_q <= req_store_failed;
    end
    if (cmd.place) begin
      tag_store[hand] <= tag_q;
    end
  end

  // directory control state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      valid_bits  <= '0;
      recent_bits <= '0;
      hand        <= '0;
      occupancy   <= '0;
    end else if (cmd.touch) begin
      recent_bits[where] <= 1'b1;
    end else if (cmd.sweep_step) begin
      recent_bits[hand] <= 1'b0;
      hand              <= hand_next;
    end else if (cmd.place) begin
      valid_bits[hand]  <= 1'b1;
      recent_bits[hand] <= 1'b1;
      hand              <= hand_next;
      if (!full) begin
        occupancy <= occupancy + ctc_pkg::OCC_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.write_result) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_result) begin
      rsp_status      <= 1'b0;
      rsp_hit         <= 1'b0;
      rsp_slot        <= '0;
      rsp_evicted     <= 1'b0;
      rsp_evicted_tag <= '0;
      unique case (cmd.res_kind)
        ctc_pkg::RES_REJECT: begin
          rsp_status <= 1'b1;
        end
        ctc_pkg::RES_HIT: begin
          rsp_hit  <= 1'b1;
          rsp_slot <= ctc_pkg::SLOT_OUT_W'(where);
        end
        ctc_pkg::RES_FILL: begin
          rsp_slot    <= ctc_pkg::SLOT_OUT_W'(hand);
          rsp_evicted <= valid_bits[hand];
          if (valid_bits[hand]) begin
            rsp_evicted_tag <= ctc_pkg::KEY_W'(tag_store[hand]);
          end
        end
        ctc_pkg::RES_ZERO: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/ctc_ctrl.sv
// controller: sequences lookup, clock sweep and placement for one request
// depends on ctc_pkg
module ctc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  ctc_pkg::dp_status_t  dir_status,
  output ctc_pkg::ctrl_cmd_t   cmd
);

  ctc_pkg::state_t state;
  ctc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '{capture: 1'b0, clear_all: 1'b0, touch: 1'b0, place: 1'b0,
                   sweep_step: 1'b0, write_result: 1'b0, res_kind: ctc_pkg::RES_ZERO};
    unique case (state)
      ctc_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = ctc_pkg::ST_LOOKUP;
        end
      end
      ctc_pkg::ST_LOOKUP: begin
        // hold until the result register can take the answer
        if (dir_status.res_free) begin
          state_next       = ctc_pkg::ST_IDLE;
          cmd.write_result = 1'b1;
          unique case (dir_status.command)
            ctc_pkg::CMD_SET: begin
              if (dir_status.store_failed) begin
                cmd.res_kind = ctc_pkg::RES_REJECT;
              end else if (dir_status.hit) begin
                cmd.touch    = 1'b1;
                cmd.res_kind = ctc_pkg::RES_HIT;
              end else if (dir_status.full) begin
                cmd.write_result = 1'b0;
                state_next       = ctc_pkg::ST_SWEEP;
              end else begin
                cmd.place    = 1'b1;
                cmd.res_kind = ctc_pkg::RES_FILL;
              end
            end
            ctc_pkg::CMD_GET: begin
              if (dir_status.hit) begin
                cmd.touch    = 1'b1;
                cmd.res_kind = ctc_pkg::RES_HIT;
              end
            end
            ctc_pkg::CMD_FLUSH: begin
              cmd.clear_all = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ctc_pkg::ST_SWEEP: begin
        // second chance: clear a set reference bit and move on
        if (dir_status.ref_at_hand) begin
          cmd.sweep_step = 1'b1;
        end else if (dir_status.res_free) begin
          cmd.place        = 1'b1;
          cmd.write_result = 1'b1;
          cmd.res_kind     = ctc_pkg::RES_FILL;
          state_next       = ctc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ctc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/clock_replacement_tag_cache.sv
// a request is captured in idle and answered from lookup once the result register is
// free, for hits, misses with room, rejects, gets and flushes; a set miss on a full
// directory first sweeps, clearing each set reference bit at the clock hand, then places.
// requests are taken only in idle, so a new one waits until the last is answered.
// reset clears valid and reference bits, clock hand and occupancy; the tag store
// is not cleared and is read only where its valid bit is set.
`include "clock_replacement_tag_cache_assert.svh"

module clock_replacement_tag_cache (
  input  logic       clk,
  input  logic       rst,
  ctc_req_if.sink    req,
  ctc_rsp_if.source  rsp
);

  ctc_pkg::ctrl_cmd_t  cmd;
  ctc_pkg::dp_status_t dp_status;

  ctc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .dir_status (dp_status),
    .cmd        (cmd)
  );

  ctc_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .req_command      (req.command),
    .req_key_tag      (req.key_tag),
    .req_store_failed (req.store_failed),
    .cmd              (cmd),
    .dir_status       (dp_status),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_hit          (rsp.hit),
    .rsp_slot         (rsp.slot),
    .rsp_evicted      (rsp.evicted),
    .rsp_evicted_tag  (rsp.evicted_tag)
  );

  `CTC_ASSERT_NEXT(a_one_at_a_time, clk, rst, req.valid && req.ready, !req.ready)
  `CTC_ASSERT_SAME(a_place_on_miss, clk, rst, cmd.place,
    dp_status.command == ctc_pkg::CMD_SET && !dp_status.hit && !dp_status.store_failed)
  `CTC_ASSERT_SAME(a_sweep_when_full, clk, rst, cmd.sweep_step,
    dp_status.full && dp_status.ref_at_hand && !cmd.write_result)
  `CTC_ASSERT_SAME(a_evict_is_fill, clk, rst, rsp.valid && rsp.evicted,
    !rsp.hit && !rsp.status)

endmodule
